[hw/rtl/ps2kb_pkg.sv]
// Shared types, constants and the set 2 scan code table of the PS/2 keyboard sender.
// Used by ps2kb_framer and ps2_keyboard_scan_code_sender; depends on nothing else.
package ps2kb_pkg;

    localparam logic [7:0] CODE_EXT      = 8'hE0;
    localparam logic [7:0] CODE_BREAK    = 8'hF0;
    localparam logic [3:0] SUB_START     = 4'd10;
    localparam logic [3:0] SUB_PARITY    = 4'd2;
    localparam logic [2:0] ADDR_KB_ENABLE = 3'h0;

    typedef struct packed {
        logic       ext;
        logic       valid;
        logic [7:0] code;
    } rom_entry_t;

    typedef struct packed {
        logic       valid;
        logic       ext;
        logic       brk;
        logic [7:0] code;
    } load_t;

    typedef struct packed {
        logic busy;
        logic strobe;
        logic data_bit;
        logic busy_after;
    } frame_stat_t;

    function automatic rom_entry_t code_rom(input logic [6:0] key);
        rom_entry_t e;
        e = '0;
        case (key)
            7'd1:  e = rom_entry_t'({2'b01, 8'h0E});
            7'd2:  e = rom_entry_t'({2'b01, 8'h16});
            7'd3:  e = rom_entry_t'({2'b01, 8'h1E});
            7'd4:  e = rom_entry_t'({2'b01, 8'h26});
            7'd5:  e = rom_entry_t'({2'b01, 8'h25});
            7'd6:  e = rom_entry_t'({2'b01, 8'h2E});
            7'd7:  e = rom_entry_t'({2'b01, 8'h36});
            7'd8:  e = rom_entry_t'({2'b01, 8'h3D});
            7'd9:  e = rom_entry_t'({2'b01, 8'h3E});
            7'd10: e = rom_entry_t'({2'b01, 8'h46});
            7'd11: e = rom_entry_t'({2'b01, 8'h45});
            7'd12: e = rom_entry_t'({2'b01, 8'h4E});
            7'd13: e = rom_entry_t'({2'b01, 8'h55});
            7'd15: e = rom_entry_t'({2'b01, 8'h66});
            7'd16: e = rom_entry_t'({2'b01, 8'h0D});
            7'd17: e = rom_entry_t'({2'b01, 8'h15});
            7'd18: e = rom_entry_t'({2'b01, 8'h1D});
            7'd19: e = rom_entry_t'({2'b01, 8'h24});
            7'd20: e = rom_entry_t'({2'b01, 8'h2D});
            7'd21: e = rom_entry_t'({2'b01, 8'h2C});
            7'd22: e = rom_entry_t'({2'b01, 8'h35});
            7'd23: e = rom_entry_t'({2'b01, 8'h3C});
            7'd24: e = rom_entry_t'({2'b01, 8'h43});
            7'd25: e = rom_entry_t'({2'b01, 8'h44});
            7'd26: e = rom_entry_t'({2'b01, 8'h4D});
            7'd27: e = rom_entry_t'({2'b01, 8'h54});
            7'd28: e = rom_entry_t'({2'b01, 8'h5B});
            7'd29: e = rom_entry_t'({2'b01, 8'h5D});
            7'd30: e = rom_entry_t'({2'b01, 8'h58});
            7'd31: e = rom_entry_t'({2'b01, 8'h1C});
            7'd32: e = rom_entry_t'({2'b01, 8'h1B});
            7'd33: e = rom_entry_t'({2'b01, 8'h23});
            7'd34: e = rom_entry_t'({2'b01, 8'h2B});
            7'd35: e = rom_entry_t'({2'b01, 8'h34});
            7'd36: e = rom_entry_t'({2'b01, 8'h33});
            7'd37: e = rom_entry_t'({2'b01, 8'h3B});
            7'd38: e = rom_entry_t'({2'b01, 8'h42});
            7'd39: e = rom_entry_t'({2'b01, 8'h4B});
            7'd40: e = rom_entry_t'({2'b01, 8'h4C});
            7'd41: e = rom_entry_t'({2'b01, 8'h52});
            7'd43: e = rom_entry_t'({2'b01, 8'h5A});
            7'd44: e = rom_entry_t'({2'b01, 8'h12});
            7'd46: e = rom_entry_t'({2'b01, 8'h1A});
            7'd47: e = rom_entry_t'({2'b01, 8'h22});
            7'd48: e = rom_entry_t'({2'b01, 8'h21});
            7'd49: e = rom_entry_t'({2'b01, 8'h2A});
            7'd50: e = rom_entry_t'({2'b01, 8'h32});
            7'd51: e = rom_entry_t'({2'b01, 8'h31});
            7'd52: e = rom_entry_t'({2'b01, 8'h3A});
            7'd53: e = rom_entry_t'({2'b01, 8'h41});
            7'd54: e = rom_entry_t'({2'b01, 8'h49});
            7'd55: e = rom_entry_t'({2'b01, 8'h4A});
            7'd57: e = rom_entry_t'({2'b01, 8'h59});
            7'd58: e = rom_entry_t'({2'b01, 8'h14});
            7'd60: e = rom_entry_t'({2'b01, 8'h11});
            7'd61: e = rom_entry_t'({2'b01, 8'h29});
            7'd62: e = rom_entry_t'({2'b11, 8'h11});
            7'd64: e = rom_entry_t'({2'b11, 8'h14});
            7'd75: e = rom_entry_t'({2'b11, 8'h70});
            7'd76: e = rom_entry_t'({2'b11, 8'h71});
            7'd79: e = rom_entry_t'({2'b11, 8'h6B});
            7'd80: e = rom_entry_t'({2'b11, 8'h6C});
            7'd81: e = rom_entry_t'({2'b11, 8'h69});
            7'd83: e = rom_entry_t'({2'b11, 8'h75});
            7'd84: e = rom_entry_t'({2'b11, 8'h72});
            7'd85: e = rom_entry_t'({2'b11, 8'h7D});
            7'd86: e = rom_entry_t'({2'b11, 8'h7A});
            7'd89: e = rom_entry_t'({2'b11, 8'h74});
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

[hw/rtl/ps2kb_framer.sv]
// Frame serializer of the PS/2 keyboard sender: holds up to three code bytes and
// presents start, data, odd parity and stop bits one at a time. Depends on ps2kb_pkg.
module ps2kb_framer
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ps2kb_pkg::load_t       load,
    input  logic                   shift_en,
    output ps2kb_pkg::frame_stat_t stat
);
    import ps2kb_pkg::*;

    logic [1:0] nrem_reg, nrem_next;
    logic [3:0] sub_reg, sub_next;
    logic [7:0] cur_reg, cur_next;
    logic       par_reg, par_next;
    logic [7:0] msg_reg [0:2];
    logic       busy;
    logic       step;
    logic       bit_val;
    logic [2:0] bit_idx;
    logic [1:0] byte_idx;

    assign busy     = (nrem_reg != 2'd0) || (sub_reg != 4'd0);
    assign step     = shift_en && busy;
    assign bit_idx  = 3'(SUB_START - sub_reg);
    assign byte_idx = nrem_reg - 2'd1;

    always_comb
    begin
        nrem_next = nrem_reg;
        sub_next  = sub_reg;
        cur_next  = cur_reg;
        par_next  = par_reg;
        bit_val   = 1'b0;
        if (load.valid)
        begin
            nrem_next = 2'd1 + 2'(load.ext) + 2'(load.brk);
            sub_next  = 4'd0;
        end
        else if (step)
        begin
            priority if (sub_reg == 4'd0)
            begin
                cur_next  = msg_reg[byte_idx];
                par_next  = 1'b1;
                bit_val   = 1'b0;
                nrem_next = nrem_reg - 2'd1;
                sub_next  = SUB_START;
            end
            else if (sub_reg > SUB_PARITY)
            begin
                bit_val  = cur_reg[bit_idx];
                par_next = par_reg ^ bit_val;
                sub_next = sub_reg - 4'd1;
            end
            else if (sub_reg == SUB_PARITY)
            begin
                bit_val  = par_reg;
                sub_next = sub_reg - 4'd1;
            end
            else
            begin
                bit_val  = 1'b1;
                sub_next = sub_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nrem_reg <= 2'd0;
            sub_reg  <= 4'd0;
            par_reg  <= 1'b0;
            cur_reg  <= 8'd0;
        end
        else
        begin
            nrem_reg <= nrem_next;
            sub_reg  <= sub_next;
            par_reg  <= par_next;
            cur_reg  <= cur_next;
        end
    end

    // The last byte of the code sits at index 0 and goes out last.
    always_ff @(posedge clk)
    begin
        if (load.valid)
        begin
            msg_reg[0] <= load.code;
            msg_reg[1] <= load.brk ? CODE_BREAK : CODE_EXT;
            msg_reg[2] <= CODE_EXT;
        end
    end

    assign stat.busy       = busy;
    assign stat.strobe     = step;
    assign stat.data_bit   = bit_val;
    assign stat.busy_after = (nrem_next != 2'd0) || (sub_next != 4'd0);

    a_load_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load.valid |-> !busy)
        else $error("code loaded while frames remain");

    a_busy_ends_on_step: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(shift_en))
        else $error("busy dropped without a presented bit");

    a_frame_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
        step && (sub_reg == 4'd0) |-> (nrem_reg != 2'd0))
        else $error("frame start with no byte left");

endmodule

[hw/rtl/ps2_keyboard_scan_code_sender.sv]
// Top level of the PS/2 keyboard scan code sender (set 2 transmitter).
// Instantiates ps2kb_framer; depends on ps2kb_pkg.
//
// Every input word on the s_axis channel is one keyboard clock tick; tuser marks
// a tick that also carries a key event, tdata holds the key number and the
// press flag. Every tick yields exactly one output word on m_axis: a strobe
// (tuser) telling whether a frame bit is presented, the data line level and a
// busy flag. The enable register at address 0 gates key events.
// Key state lives in two one-bit memories of NUM_KEYS entries (pressed and
// reported). When no code is being sent, a tick starts a scan that reads one
// key per cycle through the shared memory read port and stops at the first
// changed key. A tick that arrives while a code is being sent skips the scan.
// After reset the block sweeps both memories to zero, one entry per cycle, and
// accepts no tick meanwhile; register writes are taken.
// The output word is held in a register; a new tick is accepted while it waits,
// and the next word is written only once the receiver has taken the old one.
module ps2_keyboard_scan_code_sender
#(
    parameter int NUM_KEYS = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [6:0] key_number, [7] key_down
    input  logic        s_axis_tuser,  // [0] key_event
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [0] data_bit, [1] busy_res, [7:2] zero
    output logic        m_axis_tuser,  // [0] clock_strobe
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ps2kb_pkg::*;

    localparam int KW = $clog2(NUM_KEYS);
    localparam int WW = KW + 8;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [KW-1:0]   clr_addr_reg, clr_addr_next;
    logic [KW:0]     scan_addr_reg, scan_addr_next;
    logic [KW-1:0]   rd_addr_reg, rd_addr_next;
    logic            rd_vld_reg, rd_vld_next;
    logic            enabled_reg, enabled_next;
    logic            phase_reg, phase_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_strobe_reg, out_strobe_next;
    logic            out_bit_reg, out_bit_next;
    logic            out_busy_reg, out_busy_next;

    logic            pmem [NUM_KEYS];
    logic            rmem [NUM_KEYS];
    logic            pm_rd_reg;
    logic            rm_rd_reg;

    logic            acc_in;
    logic            cfg_we;
    logic [WW-1:0]   ev_key;
    logic            pm_we;
    logic [KW-1:0]   pm_wa;
    logic            pm_wd;
    logic            rm_we;
    logic [KW-1:0]   rm_wa;
    logic            rm_wd;
    logic            issue;
    logic [KW-1:0]   rd_index;
    logic            found;
    logic            scan_last;
    logic [WW-1:0]   rd_wide;
    rom_entry_t      entry;
    load_t           load;
    logic            emit_go;
    logic            shift_en;
    frame_stat_t     stat;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr == ADDR_KB_ENABLE);
    assign prdata = (paddr == ADDR_KB_ENABLE) ? {31'd0, enabled_reg} : 32'd0;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign acc_in        = s_axis_tvalid && s_axis_tready;
    assign ev_key        = WW'(s_axis_tdata[6:0]);

    assign pm_we = (state_reg == ST_CLEAR)
                || (acc_in && enabled_reg && s_axis_tuser && (ev_key < WW'(NUM_KEYS)));
    assign pm_wa = (state_reg == ST_CLEAR) ? clr_addr_reg : ev_key[KW-1:0];
    assign pm_wd = (state_reg == ST_CLEAR) ? 1'b0 : s_axis_tdata[7];

    assign issue     = (state_reg == ST_SCAN) && (scan_addr_reg < (KW+1)'(NUM_KEYS));
    assign rd_index  = issue ? scan_addr_reg[KW-1:0] : '0;
    assign found     = (state_reg == ST_SCAN) && rd_vld_reg && (pm_rd_reg != rm_rd_reg);
    assign scan_last = (state_reg == ST_SCAN) && rd_vld_reg
                    && (rd_addr_reg == KW'(NUM_KEYS - 1));

    assign rm_we = (state_reg == ST_CLEAR) || found;
    assign rm_wa = (state_reg == ST_CLEAR) ? clr_addr_reg : rd_addr_reg;
    assign rm_wd = (state_reg == ST_CLEAR) ? 1'b0 : pm_rd_reg;

    // Keys from 128 up have no table entry.
    assign rd_wide    = WW'(rd_addr_reg);
    assign entry      = code_rom(rd_wide[6:0]);
    assign load.valid = found && entry.valid && (rd_wide < WW'(128));
    assign load.ext   = entry.ext;
    assign load.brk   = !pm_rd_reg;
    assign load.code  = entry.code;

    assign emit_go  = (state_reg == ST_EMIT) && (!out_valid_reg || m_axis_tready);
    assign shift_en = emit_go && !phase_reg;

    always_ff @(posedge clk)
    begin
        if (pm_we)
        begin
            pmem[pm_wa] <= pm_wd;
        end
        pm_rd_reg <= pmem[rd_index];
    end

    always_ff @(posedge clk)
    begin
        if (rm_we)
        begin
            rmem[rm_wa] <= rm_wd;
        end
        rm_rd_reg <= rmem[rd_index];
    end

    ps2kb_framer u_framer
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .shift_en (shift_en),
        .stat     (stat)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        scan_addr_next  = scan_addr_reg;
        rd_addr_next    = rd_addr_reg;
        rd_vld_next     = rd_vld_reg;
        enabled_next    = cfg_we ? pwdata[0] : enabled_reg;
        phase_next      = phase_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_strobe_next = out_strobe_reg;
        out_bit_next    = out_bit_reg;
        out_busy_next   = out_busy_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + KW'(1);
                if (clr_addr_reg == KW'(NUM_KEYS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (acc_in)
                begin
                    phase_next     = !phase_reg;
                    scan_addr_next = '0;
                    rd_vld_next    = 1'b0;
                    state_next     = stat.busy ? ST_EMIT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_addr_next = scan_addr_reg + (KW+1)'(issue);
                rd_vld_next    = issue;
                rd_addr_next   = scan_addr_reg[KW-1:0];
                if (found || scan_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next  = 1'b1;
                    out_strobe_next = stat.strobe;
                    out_bit_next    = stat.data_bit;
                    out_busy_next   = stat.busy_after;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            scan_addr_reg <= '0;
            rd_addr_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            enabled_reg   <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            scan_addr_reg <= scan_addr_next;
            rd_addr_reg   <= rd_addr_next;
            rd_vld_reg    <= rd_vld_next;
            enabled_reg   <= enabled_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_strobe_reg <= out_strobe_next;
        out_bit_reg    <= out_bit_next;
        out_busy_reg   <= out_busy_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_strobe_reg;
    assign m_axis_tdata  = {6'd0, out_busy_reg, out_bit_reg};

    a_idle_line_low: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> !m_axis_tdata[0])
        else $error("data line high without a strobe");

    a_no_tick_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_axis_tready)
        else $error("tick accepted during memory clear");

    a_busy_skips_scan: assert property (@(posedge clk) disable iff (!rst_n)
        acc_in && stat.busy |=> (state_reg == ST_EMIT))
        else $error("key scan started while a code is being sent");

endmodule

[bench/ps2_keyboard_scan_code_sender_tb.sv]
// Self-checking bench for the PS/2 set 2 scan code sender: random key ticks in, frame bits out.
// A scoreboard class predicts every output word from its own key maps and frame counter.
// Depends on ps2kb_pkg and ps2_keyboard_scan_code_sender.
module ps2_keyboard_scan_code_sender_tb;

    typedef struct packed {
        bit strobe;
        bit level;
        bit busy;
    } line_word_t;

    typedef struct packed {
        bit       ext;
        bit       known;
        bit [7:0] code;
    } key_code_t;

    class scan_line_model;
        bit         enabled;
        bit         pressed[128];
        bit         reported[128];
        bit         phase;
        int         bits_left;
        bit [7:0]   msg[3];
        bit [7:0]   cur_byte;
        bit         parity;
        line_word_t words_due[$];
        int         errors;
        int         words_seen;
        int         strobes;
        int         codes;
        int         absorbed;

        function new();
            enabled = 1'b0;
            foreach (pressed[k])
            begin
                pressed[k] = 1'b0;
                reported[k] = 1'b0;
            end
            phase = 1'b0;
            bits_left = 0;
            cur_byte = 8'h00;
            parity = 1'b0;
            errors = 0;
            words_seen = 0;
            strobes = 0;
            codes = 0;
            absorbed = 0;
        endfunction

        static function key_code_t lookup(logic [6:0] key);
            key_code_t e;
            e = '0;
            case (key)
                7'd1:  e = {2'b01, 8'h0E};
                7'd2:  e = {2'b01, 8'h16};
                7'd3:  e = {2'b01, 8'h1E};
                7'd4:  e = {2'b01, 8'h26};
                7'd5:  e = {2'b01, 8'h25};
                7'd6:  e = {2'b01, 8'h2E};
                7'd7:  e = {2'b01, 8'h36};
                7'd8:  e = {2'b01, 8'h3D};
                7'd9:  e = {2'b01, 8'h3E};
                7'd10: e = {2'b01, 8'h46};
                7'd11: e = {2'b01, 8'h45};
                7'd12: e = {2'b01, 8'h4E};
                7'd13: e = {2'b01, 8'h55};
                7'd15: e = {2'b01, 8'h66};
                7'd16: e = {2'b01, 8'h0D};
                7'd17: e = {2'b01, 8'h15};
                7'd18: e = {2'b01, 8'h1D};
                7'd19: e = {2'b01, 8'h24};
                7'd20: e = {2'b01, 8'h2D};
                7'd21: e = {2'b01, 8'h2C};
                7'd22: e = {2'b01, 8'h35};
                7'd23: e = {2'b01, 8'h3C};
                7'd24: e = {2'b01, 8'h43};
                7'd25: e = {2'b01, 8'h44};
                7'd26: e = {2'b01, 8'h4D};
                7'd27: e = {2'b01, 8'h54};
                7'd28: e = {2'b01, 8'h5B};
                7'd29: e = {2'b01, 8'h5D};
                7'd30: e = {2'b01, 8'h58};
                7'd31: e = {2'b01, 8'h1C};
                7'd32: e = {2'b01, 8'h1B};
                7'd33: e = {2'b01, 8'h23};
                7'd34: e = {2'b01, 8'h2B};
                7'd35: e = {2'b01, 8'h34};
                7'd36: e = {2'b01, 8'h33};
                7'd37: e = {2'b01, 8'h3B};
                7'd38: e = {2'b01, 8'h42};
                7'd39: e = {2'b01, 8'h4B};
                7'd40: e = {2'b01, 8'h4C};
                7'd41: e = {2'b01, 8'h52};
                7'd43: e = {2'b01, 8'h5A};
                7'd44: e = {2'b01, 8'h12};
                7'd46: e = {2'b01, 8'h1A};
                7'd47: e = {2'b01, 8'h22};
                7'd48: e = {2'b01, 8'h21};
                7'd49: e = {2'b01, 8'h2A};
                7'd50: e = {2'b01, 8'h32};
                7'd51: e = {2'b01, 8'h31};
                7'd52: e = {2'b01, 8'h3A};
                7'd53: e = {2'b01, 8'h41};
                7'd54: e = {2'b01, 8'h49};
                7'd55: e = {2'b01, 8'h4A};
                7'd57: e = {2'b01, 8'h59};
                7'd58: e = {2'b01, 8'h14};
                7'd60: e = {2'b01, 8'h11};
                7'd61: e = {2'b01, 8'h29};
                7'd62: e = {2'b11, 8'h11};
                7'd64: e = {2'b11, 8'h14};
                7'd75: e = {2'b11, 8'h70};
                7'd76: e = {2'b11, 8'h71};
                7'd79: e = {2'b11, 8'h6B};
                7'd80: e = {2'b11, 8'h6C};
                7'd81: e = {2'b11, 8'h69};
                7'd83: e = {2'b11, 8'h75};
                7'd84: e = {2'b11, 8'h72};
                7'd85: e = {2'b11, 8'h7D};
                7'd86: e = {2'b11, 8'h7A};
                7'd89: e = {2'b11, 8'h74};
                default: e = '0;
            endcase
            return e;
        endfunction

        function void report_mismatch(string what);
            errors++;
            if (errors <= 40)
                $display("mismatch at output word %0d: %s", words_seen, what);
        endfunction

        // The code bytes are stored last byte first, so frame f counted down sits at index f.
        function void load_code(key_code_t e, bit make);
            bit [7:0] seq[3];
            int       n;
            n = 0;
            if (e.ext)
            begin
                seq[n] = ps2kb_pkg::CODE_EXT;
                n++;
            end
            if (!make)
            begin
                seq[n] = ps2kb_pkg::CODE_BREAK;
                n++;
            end
            seq[n] = e.code;
            n++;
            for (int i = 0; i < n; i++)
                msg[n - 1 - i] = seq[i];
            bits_left = n * 11;
            codes++;
        endfunction

        function void note_tick(bit ev, bit [6:0] key, bit down);
            line_word_t w;
            key_code_t  e;
            bit         found;
            int         sub;
            w = '0;
            found = 1'b0;
            phase = ~phase;
            if (enabled && ev)
                pressed[key] = down;
            if (bits_left == 0)
            begin
                for (int k = 0; k < 128 && !found; k++)
                begin
                    if (pressed[k] != reported[k])
                    begin
                        found = 1'b1;
                        reported[k] = pressed[k];
                        e = lookup(k[6:0]);
                        if (e.known)
                            load_code(e, pressed[k]);
                        else
                            absorbed++;
                    end
                end
            end
            if (bits_left != 0 && !phase)
            begin
                sub = bits_left % 11;
                if (sub == 0)
                begin
                    cur_byte = msg[bits_left / 11 - 1];
                    parity = 1'b1;
                    w.level = 1'b0;
                end
                else if (sub > 2)
                begin
                    w.level = cur_byte[10 - sub];
                    parity ^= w.level;
                end
                else if (sub == 2)
                    w.level = parity;
                else
                    w.level = 1'b1;
                w.strobe = 1'b1;
                bits_left--;
                strobes++;
            end
            w.busy = (bits_left != 0);
            words_due.push_back(w);
        endfunction

        function void check_word(logic strobe, logic [7:0] data);
            line_word_t w;
            if (words_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word, strobe %b data %h", strobe, data));
                return;
            end
            w = words_due[0];
            words_due.delete(0);
            if (strobe !== w.strobe)
                report_mismatch($sformatf("clock_strobe %b, expected %b", strobe, w.strobe));
            if (data[0] !== w.level)
                report_mismatch($sformatf("data_bit %b, expected %b", data[0], w.level));
            if (data[1] !== w.busy)
                report_mismatch($sformatf("busy %b, expected %b", data[1], w.busy));
            if (data[7:2] !== 6'd0)
                report_mismatch($sformatf("pad bits %b, expected zero", data[7:2]));
            words_seen++;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'h0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    scan_line_model sb;
    bit             steady = 1'b0;
    bit             hold_req = 1'b0;
    int             hold_left = 0;
    int             ticks_sent = 0;
    int             event_ticks = 0;

    ps2_keyboard_scan_code_sender dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 clk = ~clk;

    initial
    begin
        #6000000;
        $display("TB_ERROR");
        $finish;
    end

    // The receiver samples the handshake before choosing its next ready level.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tuser, m_axis_tdata);
        if (hold_req && hold_left == 0)
        begin
            hold_left = 400;
            hold_req <= 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (steady)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= 36);
    end

    task automatic send_tick(bit ev, bit [6:0] key, bit down);
        while (!steady && $urandom_range(0, 99) < 36)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= ev;
        s_axis_tdata <= {down, key};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_tick(ev, key, down);
        ticks_sent++;
        if (ev)
            event_ticks++;
    endtask

    task automatic random_ticks(int count, int event_pct);
        bit        ev;
        bit [6:0]  key;
        bit        down;
        key_code_t kc;
        repeat (count)
        begin
            ev = ($urandom_range(0, 99) < event_pct);
            if ($urandom_range(0, 9) < 7)
            begin
                do
                begin
                    key = 7'($urandom_range(0, 127));
                    kc = scan_line_model::lookup(key);
                end
                while (!kc.known);
            end
            else
                key = 7'($urandom);
            if ($urandom_range(0, 9) < 8)
                down = !sb.pressed[key];
            else
                down = 1'($urandom);
            send_tick(ev, key, down);
        end
    endtask

    task automatic drain_words(int limit);
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.words_due.size() != 0 && guard < limit)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ps2kb_pkg::ADDR_KB_ENABLE)
            sb.enabled = data[0];
    endtask

    task automatic apb_read_check(logic [2:0] addr);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== {31'd0, sb.enabled})
            sb.report_mismatch($sformatf("enable register reads %h", prdata));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_enable(bit on);
        drain_words(400000);
        repeat (140)
            @(posedge clk);
        apb_write(ps2kb_pkg::ADDR_KB_ENABLE, {31'd0, on});
        apb_read_check(ps2kb_pkg::ADDR_KB_ENABLE);
    endtask

    initial
    begin
        sb = new();
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        apb_read_check(ps2kb_pkg::ADDR_KB_ENABLE);

        // Events are dropped while the keyboard is disabled.
        send_tick(1'b1, 7'd5, 1'b1);
        send_tick(1'b1, 7'd127, 1'b1);
        set_enable(1'b1);

        send_tick(1'b1, 7'd0, 1'b1);
        send_tick(1'b1, 7'd127, 1'b1);
        send_tick(1'b1, 7'd62, 1'b1);
        send_tick(1'b1, 7'd1, 1'b1);
        send_tick(1'b1, 7'd89, 1'b1);
        send_tick(1'b1, 7'd14, 1'b1);
        send_tick(1'b0, 7'd44, 1'b1);
        send_tick(1'b1, 7'd62, 1'b0);
        send_tick(1'b1, 7'd127, 1'b0);
        send_tick(1'b1, 7'd1, 1'b0);
        send_tick(1'b1, 7'd89, 1'b0);
        send_tick(1'b1, 7'd0, 1'b0);
        send_tick(1'b1, 7'd60, 1'b1);
        send_tick(1'b1, 7'd60, 1'b0);
        send_tick(1'b1, 7'd16, 1'b1);
        send_tick(1'b1, 7'd16, 1'b0);
        send_tick(1'b1, 7'd63, 1'b1);
        send_tick(1'b1, 7'd85, 1'b1);
        send_tick(1'b1, 7'd85, 1'b0);
        send_tick(1'b0, 7'd0, 1'b0);

        random_ticks(150, 12);

        drain_words(400000);
        steady = 1'b1;
        hold_req <= 1'b1;
        random_ticks(60, 20);
        drain_words(400000);
        steady = 1'b0;

        set_enable(1'b0);
        random_ticks(80, 25);

        set_enable(1'b1);
        steady = 1'b1;
        random_ticks(100, 12);
        drain_words(400000);
        steady = 1'b0;

        set_enable(1'b0);
        set_enable(1'b1);
        random_ticks(110, 12);

        drain_words(400000);
        repeat (140)
            @(posedge clk);
        if (sb.words_due.size() != 0)
            sb.report_mismatch($sformatf("%0d words never arrived", sb.words_due.size()));

        $display("Sent %0d ticks (%0d with key events) through enable on/off and stall phases.",
                 ticks_sent, event_ticks);
        $display("Checked %0d words: %0d frame bits, %0d codes, %0d keys absorbed.",
                 sb.words_seen, sb.strobes, sb.codes, sb.absorbed);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
hw/rtl/ps2kb_pkg.sv
hw/rtl/ps2kb_framer.sv
hw/rtl/ps2_keyboard_scan_code_sender.sv
bench/ps2_keyboard_scan_code_sender_tb.sv
